>>> design/aocl_pkg.sv
// Shared types, constants and codes of the A* open/closed list engine.
package aocl_pkg;

  localparam int COORD_W        = 8;
  localparam int COST_W         = 16;
  localparam int STEP_W         = 16;
  localparam int TOTAL_W        = COST_W + 1;
  localparam int KEY_W          = 2 * COORD_W;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = COORD_W;
  localparam int OPEN_DEPTH_D   = 64;
  localparam int CLOSED_DEPTH_D = 256;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // operation codes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_NEIGH  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_GOAL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_REPEAT   = 3'd3;
  localparam logic [2:0] ST_CLOSED   = 3'd4;
  localparam logic [2:0] ST_IMPROVED = 3'd5;
  localparam logic [2:0] ST_NOTBETTER = 3'd6;
  localparam logic [2:0] ST_FULL     = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = 1'd1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [STEP_W-1:0]  step_cost;
    logic [STEP_W-1:0]  estimate;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic [COST_W-1:0]  node_cost;
    logic [TOTAL_W-1:0] node_total;
  } out_res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] h;
  } open_ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN_CLOSED, S_SCAN_OPEN, S_SHIFT
  } state_t;

  typedef enum logic [2:0] {
    SCAN_NONE, SCAN_CLOSED_M, SCAN_MIN, SCAN_MATCH, SCAN_SHIFT
  } scan_mode_t;

  typedef enum logic [2:0] {
    FIN_NONE, FIN_BEGIN, FIN_NOP, FIN_EMPTY, FIN_SKIP, FIN_SEL, FIN_NBR
  } fin_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    scan_mode_t scan_mode;
    fin_t       fin;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       open_empty;
    logic       closed_full;
    logic       found;
    logic       done;
  } dp_stat_t;

endpackage

>>> design/aocl_ctrl.sv
// Controller state machine: sequences list scans and the finishing step of each request.
module aocl_ctrl import aocl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_mode  = SCAN_NONE;
    cmd.fin        = FIN_NONE;
    busy           = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.op)
          OP_BEGIN: begin
            cmd.fin   = FIN_BEGIN;
            state_nxt = S_IDLE;
          end
          OP_SELECT: begin
            if (st.open_empty) begin
              cmd.fin   = FIN_EMPTY;
              state_nxt = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_MIN;
              state_nxt      = S_SCAN_OPEN;
            end
          end
          OP_NEIGH: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_CLOSED_M;
            state_nxt      = S_SCAN_CLOSED;
          end
          default: begin
            cmd.fin   = FIN_NOP;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN_CLOSED: begin
        if (st.done) begin
          if (st.found) begin
            cmd.fin   = FIN_SKIP;
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_MATCH;
            state_nxt      = S_SCAN_OPEN;
          end
        end
      end
      S_SCAN_OPEN: begin
        if (st.done) begin
          if (st.op != OP_SELECT) begin
            cmd.fin   = FIN_NBR;
            state_nxt = S_IDLE;
          end else if (st.closed_full) begin
            cmd.fin   = FIN_SEL;
            state_nxt = S_IDLE;
          end else begin
            // close the gap left by the chosen entry
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_SHIFT;
            state_nxt      = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (st.done) begin
          cmd.fin   = FIN_SEL;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/aocl_dp.sv
// Datapath: open and closed list memories, scan pipeline, counters and result register.
module aocl_dp import aocl_pkg::*; #(
  parameter int OPEN_DEPTH   = OPEN_DEPTH_D,
  parameter int CLOSED_DEPTH = CLOSED_DEPTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_req_t               in_req,
  input  dp_cmd_t               cmd,
  output dp_stat_t              st,
  output logic                  out_valid,
  output out_res_t              out_res
);

  localparam int OAW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
  localparam int CAW = (CLOSED_DEPTH > 1) ? $clog2(CLOSED_DEPTH) : 1;
  localparam int OCW = $clog2(OPEN_DEPTH + 1);
  localparam int CCW = $clog2(CLOSED_DEPTH + 1);
  localparam int SCW = (CCW > OCW) ? CCW : OCW;

  open_ent_t        open_mem [OPEN_DEPTH];
  logic [KEY_W-1:0] closed_mem [CLOSED_DEPTH];

  in_req_t           req_r;
  logic [COORD_W-1:0] goal_x_r, goal_y_r;
  logic [OCW-1:0]    ou_r;
  logic [CCW-1:0]    cu_r;
  logic              started_r;
  logic [COST_W-1:0] sel_cost_r;
  scan_mode_t        mode_r;
  logic [SCW-1:0]    cnt_r, lim_r, pidx_r;
  logic              pv_r;
  open_ent_t         open_rd_r;
  logic [KEY_W-1:0]  closed_rd_r;
  logic              found_r;
  logic [OAW-1:0]    best_idx_r;
  open_ent_t         best_r;
  logic [TOTAL_W-1:0] best_f_r;
  logic              out_valid_r;
  out_res_t          out_r;

  logic [KEY_W-1:0]   key;
  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W:0]   hsum;
  logic [COST_W-1:0]  h;
  logic [COST_W:0]    gsum;
  logic [COST_W-1:0]  g_new;
  logic [TOTAL_W-1:0] f_rd, f_best, f_new;
  logic               issue, open_full, closed_full;
  logic               owe;
  logic [OAW-1:0]     owaddr;
  open_ent_t          owdata;

  assign key   = {req_r.cell_x, req_r.cell_y};
  assign dx    = (req_r.cell_x >= goal_x_r) ? req_r.cell_x - goal_x_r : goal_x_r - req_r.cell_x;
  assign dy    = (req_r.cell_y >= goal_y_r) ? req_r.cell_y - goal_y_r : goal_y_r - req_r.cell_y;
  assign hsum  = {1'b0, dx} + {1'b0, dy};
  assign h     = COST_W'(hsum);
  assign gsum  = {1'b0, sel_cost_r} + {1'b0, req_r.step_cost};
  assign g_new = gsum[COST_W] ? COST_MAX : gsum[COST_W-1:0];
  assign f_rd   = {1'b0, open_rd_r.g} + {1'b0, open_rd_r.h};
  assign f_best = {1'b0, best_r.g} + {1'b0, best_r.h};
  assign f_new  = {1'b0, g_new} + {1'b0, req_r.estimate};

  assign open_full   = (ou_r >= OCW'(OPEN_DEPTH));
  assign closed_full = (cu_r >= CCW'(CLOSED_DEPTH));
  assign issue       = (mode_r != SCAN_NONE) && (cnt_r < lim_r);

  assign st.op          = req_r.operation;
  assign st.open_empty  = (ou_r == '0);
  assign st.closed_full = closed_full;
  assign st.found       = found_r;
  assign st.done        = !issue && !pv_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // open list write port
  always_comb begin
    owe    = 1'b0;
    owaddr = ou_r[OAW-1:0];
    owdata = '{key: key, g: '0, h: h};
    if (pv_r && mode_r == SCAN_SHIFT) begin
      owe    = 1'b1;
      owaddr = pidx_r[OAW-1:0] - OAW'(1);
      owdata = open_rd_r;
    end else if (cmd.fin == FIN_BEGIN) begin
      owe = !started_r && !open_full;
    end else if (cmd.fin == FIN_NBR) begin
      owdata = '{key: key, g: g_new, h: req_r.estimate};
      if (found_r) begin
        owe    = (g_new < best_r.g);
        owaddr = best_idx_r;
      end else begin
        owe = !open_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (owe) begin
      open_mem[owaddr] <= owdata;
    end
    open_rd_r <= open_mem[cnt_r[OAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin == FIN_SEL && !closed_full) begin
      closed_mem[cu_r[CAW-1:0]] <= best_r.key;
    end
    closed_rd_r <= closed_mem[cnt_r[CAW-1:0]];
  end

  // request latch and scan pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    pidx_r <= cnt_r;
    if (pv_r) begin
      case (mode_r)
        SCAN_MIN: begin
          if (!found_r || f_rd < best_f_r) begin
            best_idx_r <= pidx_r[OAW-1:0];
            best_r     <= open_rd_r;
            best_f_r   <= f_rd;
          end
        end
        SCAN_MATCH: begin
          if (!found_r && open_rd_r.key == key) begin
            best_idx_r <= pidx_r[OAW-1:0];
            best_r     <= open_rd_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      ou_r        <= '0;
      cu_r        <= '0;
      started_r   <= 1'b0;
      sel_cost_r  <= '0;
      mode_r      <= SCAN_NONE;
      cnt_r       <= '0;
      lim_r       <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GOAL_X: goal_x_r <= cfg_wdata;
          REG_GOAL_Y: goal_y_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      pv_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + SCW'(1);
      end
      if (pv_r) begin
        case (mode_r)
          SCAN_CLOSED_M: if (closed_rd_r == key) found_r <= 1'b1;
          SCAN_MATCH:    if (open_rd_r.key == key) found_r <= 1'b1;
          SCAN_MIN:      found_r <= 1'b1;
          default: begin
          end
        endcase
      end

      if (cmd.scan_start) begin
        mode_r  <= cmd.scan_mode;
        found_r <= 1'b0;
        case (cmd.scan_mode)
          SCAN_CLOSED_M: begin
            cnt_r <= '0;
            lim_r <= SCW'(cu_r);
          end
          SCAN_SHIFT: begin
            cnt_r <= SCW'(best_idx_r) + SCW'(1);
            lim_r <= SCW'(ou_r);
          end
          default: begin
            cnt_r <= '0;
            lim_r <= SCW'(ou_r);
          end
        endcase
      end else if (cmd.fin != FIN_NONE) begin
        mode_r <= SCAN_NONE;
      end

      out_valid_r <= (cmd.fin != FIN_NONE);
      case (cmd.fin)
        FIN_BEGIN: begin
          if (!started_r) begin
            started_r <= 1'b1;
            if (!open_full) ou_r <= ou_r + OCW'(1);
          end
        end
        FIN_SEL: begin
          if (!closed_full) begin
            ou_r       <= ou_r - OCW'(1);
            cu_r       <= cu_r + CCW'(1);
            sel_cost_r <= best_r.g;
          end
        end
        FIN_NBR: begin
          if (!found_r && !open_full) ou_r <= ou_r + OCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (cmd.fin)
      FIN_BEGIN: begin
        out_r <= '{status: started_r ? ST_REPEAT : (open_full ? ST_FULL : ST_OK),
                   node_x: req_r.cell_x, node_y: req_r.cell_y, node_cost: '0,
                   node_total: started_r ? '0 : {1'b0, h}};
      end
      FIN_EMPTY: out_r <= '{status: ST_EMPTY, default: '0};
      FIN_SKIP: begin
        out_r <= '{status: ST_CLOSED, node_x: req_r.cell_x, node_y: req_r.cell_y,
                   node_cost: '0, node_total: '0};
      end
      FIN_SEL: begin
        out_r <= '{status: closed_full ? ST_FULL :
                           ((best_r.key == {goal_x_r, goal_y_r}) ? ST_GOAL : ST_OK),
                   node_x: best_r.key[KEY_W-1:COORD_W], node_y: best_r.key[COORD_W-1:0],
                   node_cost: best_r.g, node_total: f_best};
      end
      FIN_NBR: begin
        if (found_r && !(g_new < best_r.g)) begin
          out_r <= '{status: ST_NOTBETTER, node_x: req_r.cell_x, node_y: req_r.cell_y,
                     node_cost: best_r.g, node_total: f_best};
        end else begin
          out_r <= '{status: found_r ? ST_IMPROVED : (open_full ? ST_FULL : ST_OK),
                     node_x: req_r.cell_x, node_y: req_r.cell_y,
                     node_cost: g_new, node_total: f_new};
        end
      end
      default: out_r <= '{status: ST_OK, default: '0};
    endcase
  end

endmodule

>>> design/astar_open_closed_list_engine_top.sv
// Top level of the A* open/closed list engine: controller plus datapath.
//
// Requests enter on in_req, taken at a clock edge where start is high and busy
// is low. Each request gives exactly one result on out_res, marked by out_valid
// for one cycle; the receiver cannot stall it. busy drops in the same cycle the
// result shows, so the next request may be taken at the edge that takes the result.
// Steps of each request after the accepting edge:
//   begin, unused code, select on an empty list: finished straight from dispatch
//   select: one open entry a cycle through the min scan and then, unless the
//     closed list is full, the shift that closes the gap
//   neighbor: one entry a cycle through the closed list match scan and then,
//     if the cell is not closed, the open list match scan.
// One request is in flight at a time; no new request is taken until the last result shows.
// Each list memory has a single read port, so the scans read one entry at a time.
// The user must write the goal registers on the cfg_ port only while busy is low; the block does not enforce it.
// Reset (rst_n low, synchronous) empties both lists, clears the started flag,
// the selected cost and the goal registers; no clearing pass is needed.
module astar_open_closed_list_engine_top import aocl_pkg::*; #(
  parameter int OPEN_DEPTH   = OPEN_DEPTH_D,
  parameter int CLOSED_DEPTH = CLOSED_DEPTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_req,
  output logic                  out_valid,
  output out_res_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  aocl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  aocl_dp #(
    .OPEN_DEPTH   (OPEN_DEPTH),
    .CLOSED_DEPTH (CLOSED_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> sim/tb_astar_open_closed_list_engine_top.sv
// Testbench of the A* open/closed list engine: random searches checked against a predictor.
module tb_astar_open_closed_list_engine_top;
  import aocl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_res_t              out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  astar_open_closed_list_engine_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [KEY_W-1:0]   open_key[OPEN_DEPTH_D];
  logic [COST_W-1:0]  open_g[OPEN_DEPTH_D];
  logic [COST_W-1:0]  open_h[OPEN_DEPTH_D];
  int                 open_n;
  logic [KEY_W-1:0]   closed_key[CLOSED_DEPTH_D];
  int                 closed_n;
  bit                 started;
  logic [COST_W-1:0]  sel_g;
  logic [COORD_W-1:0] goal_x, goal_y;

  in_req_t   pending_reqs[$];
  out_res_t  outcome_q[$];
  logic [KEY_W-1:0] offered_cells[$];
  int  idle_pct;
  bit  req_taken;
  int  mismatches;
  int  quiet_cycles;

  function automatic logic [COST_W-1:0] sat_cost(logic [COST_W:0] v);
    return v[COST_W] ? COST_MAX : v[COST_W-1:0];
  endfunction

  task automatic compute_outcome(in_req_t r);
    out_res_t          o;
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] g, h;
    logic [COORD_W-1:0] dx, dy;
    logic [TOTAL_W-1:0] f, fb;
    int best, i;
    bit hit;
    o = '0;
    key = {r.cell_x, r.cell_y};
    hit = 0;
    case (r.operation)
      OP_BEGIN: begin
        o.node_x = r.cell_x;
        o.node_y = r.cell_y;
        if (started) begin
          o.status = ST_REPEAT;
        end else begin
          started = 1;
          dx = (r.cell_x >= goal_x) ? r.cell_x - goal_x : goal_x - r.cell_x;
          dy = (r.cell_y >= goal_y) ? r.cell_y - goal_y : goal_y - r.cell_y;
          h = sat_cost((COST_W+1)'(dx) + (COST_W+1)'(dy));
          o.node_total = {1'b0, h};
          if (open_n >= OPEN_DEPTH_D) begin
            o.status = ST_FULL;
          end else begin
            open_key[open_n] = key;
            open_g[open_n] = '0;
            open_h[open_n] = h;
            open_n++;
            o.status = ST_OK;
          end
        end
      end
      OP_SELECT: begin
        if (open_n == 0) begin
          o.status = ST_EMPTY;
        end else begin
          best = 0;
          for (i = 1; i < open_n; i++) begin
            f  = {1'b0, open_g[i]} + {1'b0, open_h[i]};
            fb = {1'b0, open_g[best]} + {1'b0, open_h[best]};
            if (f < fb) best = i;
          end
          {o.node_x, o.node_y} = open_key[best];
          o.node_cost = open_g[best];
          o.node_total = {1'b0, open_g[best]} + {1'b0, open_h[best]};
          if (closed_n >= CLOSED_DEPTH_D) begin
            o.status = ST_FULL;
          end else begin
            closed_key[closed_n] = open_key[best];
            closed_n++;
            sel_g = open_g[best];
            o.status = (open_key[best] == {goal_x, goal_y}) ? ST_GOAL : ST_OK;
            for (i = best; i + 1 < open_n; i++) begin
              open_key[i] = open_key[i+1];
              open_g[i] = open_g[i+1];
              open_h[i] = open_h[i+1];
            end
            open_n--;
          end
        end
      end
      OP_NEIGH: begin
        o.node_x = r.cell_x;
        o.node_y = r.cell_y;
        for (i = 0; i < closed_n; i++)
          if (closed_key[i] == key) hit = 1;
        if (hit) begin
          o.status = ST_CLOSED;
        end else begin
          g = sat_cost({1'b0, sel_g} + {1'b0, r.step_cost});
          h = r.estimate;
          for (i = 0; i < open_n && !hit; i++) begin
            if (open_key[i] == key) begin
              hit = 1;
              if (g < open_g[i]) begin
                open_g[i] = g;
                open_h[i] = h;
                o.status = ST_IMPROVED;
                o.node_cost = g;
                o.node_total = {1'b0, g} + {1'b0, h};
              end else begin
                o.status = ST_NOTBETTER;
                o.node_cost = open_g[i];
                o.node_total = {1'b0, open_g[i]} + {1'b0, open_h[i]};
              end
            end
          end
          if (!hit) begin
            o.node_cost = g;
            o.node_total = {1'b0, g} + {1'b0, h};
            if (open_n >= OPEN_DEPTH_D) begin
              o.status = ST_FULL;
            end else begin
              open_key[open_n] = key;
              open_g[open_n] = g;
              open_h[open_n] = h;
              open_n++;
              o.status = ST_OK;
            end
          end
        end
      end
      default: o = '0;
    endcase
    outcome_q = {outcome_q, o};
  endtask

  function automatic in_req_t mk(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                 logic [15:0] s, logic [15:0] e);
    in_req_t r;
    r.operation = op;
    r.cell_x = x;
    r.cell_y = y;
    r.step_cost = s;
    r.estimate = e;
    return r;
  endfunction

  task automatic queue_req(in_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!start || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_req <= pending_reqs.pop_front();
        start  <= 1'b1;
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_res_t exp_res;
    if (rst_n) begin
      req_taken <= start && !busy;
      if (start && !busy) compute_outcome(in_req);
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_res);
        end else begin
          exp_res = outcome_q.pop_front();
          if (out_res !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", exp_res, out_res);
          end
        end
      end
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_goal(logic [7:0] x, logic [7:0] y);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_GOAL_X; cfg_wdata <= x;
    goal_x = x;
    @(negedge clk);
    cfg_index <= REG_GOAL_Y; cfg_wdata <= y;
    goal_y = y;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || start || busy || outcome_q.size() > 0);
  endtask

  task automatic queue_random(int count, int sel_pct);
    in_req_t r;
    int pick, k;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      r = mk(OP_SELECT, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      if (pick >= 97) begin
        r.operation = ($urandom_range(1)) ? OP_SPARE : OP_BEGIN;
      end else if (pick >= sel_pct) begin
        r.operation = OP_NEIGH;
        pick = $urandom_range(99);
        if (pick < 40 && offered_cells.size() > 0)
          {r.cell_x, r.cell_y} = offered_cells[$urandom_range(offered_cells.size() - 1)];
        else if (pick < 45)
          {r.cell_x, r.cell_y} = {goal_x, goal_y};
        else
          offered_cells = {offered_cells, {r.cell_x, r.cell_y}};
        pick = $urandom_range(9);
        r.step_cost = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0 :
                      16'($urandom_range(1, 50));
        pick = $urandom_range(9);
        r.estimate = (pick == 0) ? 16'hFFFF : (pick < 3) ? 16'($urandom) :
                     16'($urandom_range(0, 60));
      end
      queue_req(r);
    end
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_req = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    open_n = 0; closed_n = 0; started = 0; sel_g = '0;
    goal_x = '0; goal_y = '0;
    idle_pct = 0; req_taken = 0; mismatches = 0; quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_goal(8'd5, 8'd7);
    idle_pct = 20;
    queue_req(mk(OP_SELECT, 8'h00, 8'h00, 16'h0, 16'h0));
    queue_req(mk(OP_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    queue_req(mk(OP_NEIGH, 8'd3, 8'd3, 16'd10, 16'd20));
    queue_req(mk(OP_NEIGH, 8'd3, 8'd3, 16'd5, 16'd30));
    queue_req(mk(OP_NEIGH, 8'd3, 8'd3, 16'd40, 16'd1));
    queue_req(mk(OP_NEIGH, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF));
    queue_req(mk(OP_NEIGH, 8'h00, 8'hFF, 16'h0, 16'h0));
    queue_req(mk(OP_NEIGH, 8'd5, 8'd7, 16'd1, 16'd0));
    queue_req(mk(OP_SELECT, 8'h00, 8'h00, 16'h0, 16'h0));
    queue_req(mk(OP_SELECT, 8'h00, 8'h00, 16'h0, 16'h0));
    queue_req(mk(OP_NEIGH, 8'd5, 8'd7, 16'd2, 16'd2));
    queue_req(mk(OP_NEIGH, 8'hAA, 8'h55, 16'hFFFF, 16'h1234));
    queue_req(mk(OP_SELECT, 8'h00, 8'h00, 16'h0, 16'h0));
    // neighbor-heavy: fill the open list before the start cell arrives
    queue_random(160, 5);
    queue_req(mk(OP_BEGIN, 8'hFF, 8'hFF, 16'h0, 16'h0));
    queue_req(mk(OP_BEGIN, 8'h00, 8'h00, 16'h0, 16'h0));
    wait_drained();

    write_goal(8'hFF, 8'hFF);
    idle_pct = 84;
    queue_random(120, 62);
    wait_drained();

    write_goal(8'($urandom), 8'($urandom));
    idle_pct = 0;
    queue_random(110, 62);
    wait_drained();

    write_goal(8'h00, 8'h00);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
